// ===== rtl/anc_pkg.sv =====
// shared types, codes and constants of the arp neighbor cache
`default_nettype none
package anc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = IDX_W + 1;

    localparam logic [15:0] HW_ETHER       = 16'h0001;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
    localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
    localparam logic [15:0] OP_REQUEST     = 16'h0001;

    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] IP_BCAST  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_RESOLVE = 2'd0,
        FUNC_LOOKUP  = 2'd1,
        FUNC_FRAME   = 2'd2,
        FUNC_TICK    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_REPLY   = 2'd2,
        KIND_RELEASE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_TRY      = 3'd1,
        STS_UNREACH  = 3'd2,
        STS_NOTFOUND = 3'd3,
        STS_DROPPED  = 3'd4
    } t_sts;

    typedef enum logic [1:0] {
        ENT_FREE    = 2'd0,
        ENT_PENDING = 2'd1,
        ENT_VALID   = 2'd2
    } t_ent;

    typedef enum logic [2:0] {
        CFG_OWN_IP   = 3'd0,
        CFG_OWN_MAC  = 3'd1,
        CFG_RETRY    = 3'd2,
        CFG_LIFETIME = 3'd3,
        CFG_LIMIT    = 3'd4
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EMIT1,
        S_EMIT2,
        S_EMITS,
        S_TSCAN,
        S_TFIND,
        S_TDATA
    } t_state;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [47:0] dl;
        logic [3:0]  tries;
        logic        held;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage
`default_nettype wire

// ===== rtl/anc_ram.sv =====
// single write port, single registered read port entry memory
`default_nettype none
module anc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/arp_neighbor_cache.sv =====
// arp neighbor cache: entry scan sequencer around one entry memory
//
// channel   dir  handshake                 payload
// s         in   i_s_tvalid / o_s_tready   i_s_tdata, i_s_tuser (func)
// m         out  o_m_tvalid / i_m_tready   o_m_tdata, o_m_tuser (kind), o_m_tlast
// cfg       in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one item at a time: a scan reads the sixteen entries, one memory read a cycle,
// then a decide state and an emit state for each possible beat.
// a tick scans the same way, then visits each retried entry with a find and a read step.
// broadcast and zero-address resolves and dropped frames skip the scan.
// reset clears entry status flops at once; the memory needs no clearing.
// a stalled output holds its beat; the sequencer waits on it.
`default_nettype none
module arp_neighbor_cache
    import anc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // now, addr_ip, hold_packet, frame_long_enough, hw_type, proto_type,
    // hw_len, proto_len, opcode, sender_ip, sender_mac
    input  wire logic [231:0] i_s_tdata,
    // func
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // status, mac, ip, slot, pending_count
    output logic [95:0]       o_m_tdata,
    // kind
    output logic [1:0]        o_m_tuser,
    output logic              o_m_tlast,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [47:0]  i_cfg_data
);

    // configuration
    logic [31:0] r_own_ip, r_retry_iv, r_life;
    logic [47:0] r_own_mac;
    logic [3:0]  r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip   <= '0;
            r_own_mac  <= '0;
            r_retry_iv <= 32'd1000;
            r_life     <= 32'd60000;
            r_limit    <= 4'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OWN_IP:   r_own_ip   <= i_cfg_data[31:0];
                CFG_OWN_MAC:  r_own_mac  <= i_cfg_data;
                CFG_RETRY:    r_retry_iv <= i_cfg_data[31:0];
                CFG_LIFETIME: r_life     <= i_cfg_data[31:0];
                CFG_LIMIT:    r_limit    <= i_cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    // input decode
    logic [47:0] in_now, in_smac;
    logic [31:0] in_addr, in_sip;
    logic        in_hold, in_long, in_frame_ok;
    logic [15:0] in_htype, in_ptype, in_op;
    logic [7:0]  in_hlen, in_plen;

    assign in_now   = i_s_tdata[47:0];
    assign in_addr  = i_s_tdata[79:48];
    assign in_hold  = i_s_tdata[80];
    assign in_long  = i_s_tdata[81];
    assign in_htype = i_s_tdata[97:82];
    assign in_ptype = i_s_tdata[113:98];
    assign in_hlen  = i_s_tdata[121:114];
    assign in_plen  = i_s_tdata[129:122];
    assign in_op    = i_s_tdata[145:130];
    assign in_sip   = i_s_tdata[177:146];
    assign in_smac  = i_s_tdata[225:178];
    assign in_frame_ok = in_long && in_htype == HW_ETHER && in_ptype == PROTO_IPV4 &&
                         in_hlen == HW_ADDR_LEN && in_plen == PROTO_ADDR_LEN;

    // state
    t_state r_state, n_state;
    t_ent   r_status [ENTRIES];
    t_ent   n_status [ENTRIES];
    logic [ENTRIES-1:0] r_retry, n_retry;

    // held item
    t_func       r_func, n_func;
    logic [47:0] r_now, n_now, r_smac, n_smac;
    logic [31:0] r_addr, n_addr, r_sip, n_sip, r_key, n_key;
    logic        r_hold, n_hold, r_is_req, n_is_req;

    // scan
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_pv, n_pv;
    logic [IDX_W-1:0] r_pidx, n_pidx;
    logic             r_found, n_found, r_hbest, n_hbest;
    logic [IDX_W-1:0] r_midx, n_midx, r_best, n_best, r_tidx, n_tidx;
    t_entry           r_mdata, n_mdata;
    logic [47:0]      r_best_dl, n_best_dl;

    // pending beats
    logic        r_e1, n_e1, r_e2, n_e2;
    t_kind       r_b1kind, n_b1kind;
    logic [47:0] r_b1mac, n_b1mac, r_smo, n_smo;
    logic [31:0] r_b1ip, n_b1ip;
    logic [IDX_W-1:0] r_b1slot, n_b1slot, r_sslot, n_sslot;
    t_sts        r_sc, n_sc;

    // output register
    logic        r_ovld;
    t_kind       r_okind;
    t_sts        r_ostat;
    logic [47:0] r_omac;
    logic [31:0] r_oip;
    logic [3:0]  r_oslot;
    logic [4:0]  r_opend;
    logic        r_olast;

    logic        out_free, out_ld, out_last;
    t_kind       out_kind;
    t_sts        out_stat;
    logic [47:0] out_mac;
    logic [31:0] out_ip;
    logic [IDX_W-1:0] out_slot;

    // memory
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    t_entry           ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;

    anc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rbits)
    );
    assign ram_rdata = t_entry'(ram_rbits);

    // saturating deadlines
    logic [48:0] sum_retry, sum_life;
    logic [47:0] dl_retry, dl_life;
    assign sum_retry = {1'b0, r_now} + {17'd0, r_retry_iv};
    assign sum_life  = {1'b0, r_now} + {17'd0, r_life};
    assign dl_retry  = sum_retry[48] ? MAC_BCAST : sum_retry[47:0];
    assign dl_life   = sum_life[48] ? MAC_BCAST : sum_life[47:0];

    // pending count
    logic [CNT_W-1:0] pend_cnt;
    always_comb begin
        pend_cnt = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_status[i] == ENT_PENDING) begin
                pend_cnt = pend_cnt + CNT_W'(1);
            end
        end
    end

    // decide helpers
    logic             stale, hit, hit_valid, ffound, claim_ok, for_us, was_pend;
    logic [IDX_W-1:0] ffidx, claim_idx, fe;
    logic             tfound;
    logic [IDX_W-1:0] tnext;

    always_comb begin
        stale     = r_found && r_status[r_midx] == ENT_VALID && r_now >= r_mdata.dl;
        hit       = r_found && !stale;
        hit_valid = hit && r_status[r_midx] == ENT_VALID;
        ffound    = 1'b0;
        ffidx     = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!ffound && (r_status[i] == ENT_FREE ||
                            (stale && r_midx == IDX_W'(i)))) begin
                ffound = 1'b1;
                ffidx  = IDX_W'(i);
            end
        end
        claim_ok  = ffound || r_hbest;
        claim_idx = ffound ? ffidx : r_best;
        for_us    = r_own_ip != '0 && r_addr == r_own_ip;
        was_pend  = hit && r_status[r_midx] == ENT_PENDING;
        fe        = hit ? r_midx : claim_idx;
        tfound    = 1'b0;
        tnext     = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!tfound && r_retry[i]) begin
                tfound = 1'b1;
                tnext  = IDX_W'(i);
            end
        end
    end

    assign out_free   = !r_ovld || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        t_entry d;
        d         = ram_rdata;
        n_state   = r_state;
        n_status  = r_status;
        n_retry   = r_retry;
        n_func    = r_func;
        n_now     = r_now;
        n_smac    = r_smac;
        n_addr    = r_addr;
        n_sip     = r_sip;
        n_key     = r_key;
        n_hold    = r_hold;
        n_is_req  = r_is_req;
        n_idx     = r_idx;
        n_pv      = 1'b0;
        n_pidx    = r_idx[IDX_W-1:0];
        n_found   = r_found;
        n_hbest   = r_hbest;
        n_midx    = r_midx;
        n_best    = r_best;
        n_tidx    = r_tidx;
        n_mdata   = r_mdata;
        n_best_dl = r_best_dl;
        n_e1      = r_e1;
        n_e2      = r_e2;
        n_b1kind  = r_b1kind;
        n_b1mac   = r_b1mac;
        n_b1ip    = r_b1ip;
        n_b1slot  = r_b1slot;
        n_sc      = r_sc;
        n_smo     = r_smo;
        n_sslot   = r_sslot;
        ram_we    = 1'b0;
        ram_waddr = r_pidx;
        ram_wdata = d;
        ram_raddr = r_idx[IDX_W-1:0];
        out_ld    = 1'b0;
        out_kind  = KIND_STATUS;
        out_stat  = STS_OK;
        out_mac   = '0;
        out_ip    = '0;
        out_slot  = '0;
        out_last  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_func   = t_func'(i_s_tuser);
                    n_now    = in_now;
                    n_addr   = in_addr;
                    n_sip    = in_sip;
                    n_smac   = in_smac;
                    n_hold   = in_hold;
                    n_is_req = in_op == OP_REQUEST;
                    n_key    = (t_func'(i_s_tuser) == FUNC_FRAME) ? in_sip : in_addr;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_hbest  = 1'b0;
                    n_retry  = '0;
                    n_e1     = 1'b0;
                    n_e2     = 1'b0;
                    n_sc     = STS_OK;
                    n_smo    = '0;
                    n_sslot  = '0;
                    unique case (t_func'(i_s_tuser))
                        FUNC_RESOLVE: begin
                            if (in_addr == IP_BCAST || in_addr == '0) begin
                                n_smo   = MAC_BCAST;
                                n_state = S_EMITS;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        FUNC_LOOKUP: n_state = S_SCAN;
                        FUNC_FRAME: begin
                            if (in_frame_ok) begin
                                n_state = S_SCAN;
                            end else begin
                                n_sc    = STS_DROPPED;
                                n_state = S_EMITS;
                            end
                        end
                        FUNC_TICK: n_state = S_TSCAN;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end

            S_SCAN, S_TSCAN: begin
                if (r_idx != CNT_W'(ENTRIES)) begin
                    n_idx = r_idx + CNT_W'(1);
                    n_pv  = 1'b1;
                end
                if (r_pv) begin
                    if (r_state == S_SCAN) begin
                        if (!r_found && r_status[r_pidx] != ENT_FREE && d.ip == r_key) begin
                            n_found = 1'b1;
                            n_midx  = r_pidx;
                            n_mdata = d;
                        end
                        if (r_status[r_pidx] == ENT_VALID &&
                            (!r_hbest || d.dl < r_best_dl)) begin
                            n_hbest   = 1'b1;
                            n_best    = r_pidx;
                            n_best_dl = d.dl;
                        end
                    end else begin
                        if (r_status[r_pidx] == ENT_VALID && r_now >= d.dl) begin
                            n_status[r_pidx] = ENT_FREE;
                        end else if (r_status[r_pidx] == ENT_PENDING && r_now >= d.dl) begin
                            if (d.tries >= r_limit) begin
                                n_status[r_pidx] = ENT_FREE;
                            end else begin
                                ram_we          = 1'b1;
                                ram_wdata       = d;
                                ram_wdata.tries = d.tries + 4'd1;
                                ram_wdata.dl    = dl_retry;
                                n_retry[r_pidx] = 1'b1;
                            end
                        end
                    end
                end
                if (r_idx == CNT_W'(ENTRIES) && !r_pv) begin
                    n_state = (r_state == S_SCAN) ? S_DECIDE : S_TFIND;
                end
            end

            S_DECIDE: begin
                n_state = S_EMIT1;
                if (stale) begin
                    n_status[r_midx] = ENT_FREE;
                end
                priority case (r_func)
                    FUNC_RESOLVE: begin
                        if (hit_valid) begin
                            n_sc    = STS_OK;
                            n_smo   = r_mdata.mac;
                            n_sslot = r_midx;
                        end else if (hit) begin
                            ram_we         = 1'b1;
                            ram_waddr      = r_midx;
                            ram_wdata      = r_mdata;
                            ram_wdata.held = r_hold;
                            n_sc           = STS_TRY;
                            n_sslot        = r_midx;
                        end else if (claim_ok) begin
                            ram_we    = 1'b1;
                            ram_waddr = claim_idx;
                            ram_wdata = '{ip: r_addr, mac: '0, dl: dl_retry,
                                          tries: 4'd1, held: r_hold};
                            n_status[claim_idx] = ENT_PENDING;
                            n_e1     = 1'b1;
                            n_b1kind = KIND_REQUEST;
                            n_b1mac  = MAC_BCAST;
                            n_b1ip   = r_addr;
                            n_b1slot = claim_idx;
                            n_sc     = STS_TRY;
                            n_sslot  = claim_idx;
                        end else begin
                            n_sc = STS_UNREACH;
                        end
                    end
                    FUNC_LOOKUP: begin
                        if (hit_valid) begin
                            n_sc  = STS_OK;
                            n_smo = r_mdata.mac;
                        end else begin
                            n_sc = STS_NOTFOUND;
                        end
                    end
                    default: begin
                        if (hit || (r_is_req && for_us && claim_ok)) begin
                            ram_we    = 1'b1;
                            ram_waddr = fe;
                            ram_wdata = '{ip: r_sip, mac: r_smac, dl: dl_life,
                                          tries: 4'd0, held: 1'b0};
                            n_status[fe] = ENT_VALID;
                            if (was_pend && r_mdata.held) begin
                                n_e1     = 1'b1;
                                n_b1kind = KIND_RELEASE;
                                n_b1mac  = r_smac;
                                n_b1ip   = '0;
                                n_b1slot = fe;
                            end
                        end
                        n_e2 = r_is_req && for_us;
                    end
                endcase
            end

            S_EMIT1: begin
                if (!r_e1) begin
                    n_state = S_EMIT2;
                end else if (out_free) begin
                    out_ld   = 1'b1;
                    out_kind = r_b1kind;
                    out_mac  = r_b1mac;
                    out_ip   = r_b1ip;
                    out_slot = r_b1slot;
                    n_state  = S_EMIT2;
                end
            end

            S_EMIT2: begin
                if (!r_e2) begin
                    n_state = S_EMITS;
                end else if (out_free) begin
                    out_ld   = 1'b1;
                    out_kind = KIND_REPLY;
                    out_mac  = r_smac;
                    out_ip   = r_sip;
                    n_state  = S_EMITS;
                end
            end

            S_EMITS: begin
                if (out_free) begin
                    out_ld   = 1'b1;
                    out_stat = r_sc;
                    out_mac  = r_smo;
                    out_slot = r_sslot;
                    out_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_TFIND: begin
                ram_raddr = tnext;
                n_tidx    = tnext;
                n_state   = tfound ? S_TDATA : S_EMITS;
            end

            S_TDATA: begin
                ram_raddr = r_tidx;
                if (out_free) begin
                    out_ld          = 1'b1;
                    out_kind        = KIND_REQUEST;
                    out_mac         = MAC_BCAST;
                    out_ip          = d.ip;
                    out_slot        = r_tidx;
                    n_retry[r_tidx] = 1'b0;
                    n_state         = S_TFIND;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_retry <= '0;
            r_pv    <= 1'b0;
            r_ovld  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_status[i] <= ENT_FREE;
            end
        end else begin
            r_state  <= n_state;
            r_retry  <= n_retry;
            r_pv     <= n_pv;
            r_status <= n_status;
            if (out_ld) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_now     <= n_now;
        r_smac    <= n_smac;
        r_addr    <= n_addr;
        r_sip     <= n_sip;
        r_key     <= n_key;
        r_hold    <= n_hold;
        r_is_req  <= n_is_req;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_found   <= n_found;
        r_hbest   <= n_hbest;
        r_midx    <= n_midx;
        r_best    <= n_best;
        r_tidx    <= n_tidx;
        r_mdata   <= n_mdata;
        r_best_dl <= n_best_dl;
        r_e1      <= n_e1;
        r_e2      <= n_e2;
        r_b1kind  <= n_b1kind;
        r_b1mac   <= n_b1mac;
        r_b1ip    <= n_b1ip;
        r_b1slot  <= n_b1slot;
        r_sc      <= n_sc;
        r_smo     <= n_smo;
        r_sslot   <= n_sslot;
        if (out_ld) begin
            r_okind <= out_kind;
            r_ostat <= out_stat;
            r_omac  <= out_mac;
            r_oip   <= out_ip;
            r_oslot <= 4'(out_slot);
            r_opend <= 5'(pend_cnt);
            r_olast <= out_last;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {4'd0, r_opend, r_oslot, r_oip, r_omac, r_ostat};

endmodule
`default_nettype wire

// ===== bench/tb_arp_neighbor_cache.sv =====
// self-checking bench for the arp neighbor cache: random and directed cases
`default_nettype none
module tb_arp_neighbor_cache;
    import anc_pkg::*;

    typedef struct {
        t_func       func;
        logic [47:0] now;
        logic [31:0] addr;
        logic        hold;
        logic        long_ok;
        logic [15:0] htype;
        logic [15:0] ptype;
        logic [7:0]  hlen;
        logic [7:0]  plen;
        logic [15:0] op;
        logic [31:0] sip;
        logic [47:0] smac;
    } t_req;

    typedef struct {
        t_kind       kind;
        t_sts        sts;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [3:0]  slot;
        logic [4:0]  pend;
        logic        last;
    } t_beat;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [231:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [95:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [47:0]  i_cfg_data = '0;

    arp_neighbor_cache DUT (.*);

    always #2 i_clk = ~i_clk;

    // cache shadow and register copy
    t_ent        sh_status [ENTRIES];
    logic [31:0] sh_ip     [ENTRIES];
    logic [47:0] sh_mac    [ENTRIES];
    logic [47:0] sh_dl     [ENTRIES];
    logic [3:0]  sh_tries  [ENTRIES];
    logic        sh_held   [ENTRIES];
    logic [31:0] r_own_ip = '0, r_retry = 32'd1000, r_life = 32'd60000;
    logic [47:0] r_own_mac = '0;
    logic [3:0]  r_limit = 4'd3;

    t_beat       expected_beats[$];
    logic [47:0] now_t = '0;
    logic [31:0] ip_pool [24];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          quiet = 0;
    int          stall_left = 0;

    function automatic logic [47:0] deadline_after(logic [47:0] t, logic [31:0] d);
        logic [48:0] s;
        s = {1'b0, t} + {17'b0, d};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    // first live match; a stale valid match is dropped and counts as a miss
    function automatic int match_entry(logic [31:0] ip, logic [47:0] t);
        for (int i = 0; i < ENTRIES; i++) begin
            if (sh_status[i] == ENT_FREE || sh_ip[i] != ip) continue;
            if (sh_status[i] == ENT_VALID && t >= sh_dl[i]) begin
                sh_status[i] = ENT_FREE;
                return -1;
            end
            return i;
        end
        return -1;
    endfunction

    function automatic int claim_entry();
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (sh_status[i] == ENT_FREE) return i;
            if (sh_status[i] == ENT_VALID && (best < 0 || sh_dl[i] < sh_dl[best])) best = i;
        end
        return best;
    endfunction

    function automatic t_beat mk(t_kind k, t_sts s, logic [47:0] m, logic [31:0] ip, int sl);
        t_beat b;
        b.kind = k; b.sts = s; b.mac = m; b.ip = ip; b.slot = 4'(sl);
        b.pend = '0; b.last = 1'b0;
        return b;
    endfunction

    function automatic void predict_cache(t_req r);
        t_beat out[$];
        int    e;
        int    pend;
        bit    for_us, is_req, prior_pend;
        pend = 0;
        case (r.func)
            FUNC_RESOLVE: begin
                if (r.addr == IP_BCAST || r.addr == 0) begin
                    out.push_back(mk(KIND_STATUS, STS_OK, MAC_BCAST, 0, 0));
                end else begin
                    e = match_entry(r.addr, r.now);
                    if (e >= 0 && sh_status[e] == ENT_VALID) begin
                        out.push_back(mk(KIND_STATUS, STS_OK, sh_mac[e], 0, e));
                    end else if (e >= 0) begin
                        sh_held[e] = r.hold;
                        out.push_back(mk(KIND_STATUS, STS_TRY, 0, 0, e));
                    end else begin
                        e = claim_entry();
                        if (e < 0) begin
                            out.push_back(mk(KIND_STATUS, STS_UNREACH, 0, 0, 0));
                        end else begin
                            sh_ip[e] = r.addr; sh_status[e] = ENT_PENDING;
                            sh_tries[e] = 4'd1; sh_dl[e] = deadline_after(r.now, r_retry);
                            sh_held[e] = r.hold;
                            out.push_back(mk(KIND_REQUEST, STS_OK, MAC_BCAST, r.addr, e));
                            out.push_back(mk(KIND_STATUS, STS_TRY, 0, 0, e));
                        end
                    end
                end
            end
            FUNC_LOOKUP: begin
                e = match_entry(r.addr, r.now);
                if (e >= 0 && sh_status[e] == ENT_VALID)
                    out.push_back(mk(KIND_STATUS, STS_OK, sh_mac[e], 0, 0));
                else
                    out.push_back(mk(KIND_STATUS, STS_NOTFOUND, 0, 0, 0));
            end
            FUNC_FRAME: begin
                if (!r.long_ok || r.htype != HW_ETHER || r.ptype != PROTO_IPV4 ||
                    r.hlen != HW_ADDR_LEN || r.plen != PROTO_ADDR_LEN) begin
                    out.push_back(mk(KIND_STATUS, STS_DROPPED, 0, 0, 0));
                end else begin
                    for_us = r_own_ip != 0 && r.addr == r_own_ip;
                    is_req = r.op == OP_REQUEST;
                    e = match_entry(r.sip, r.now);
                    if (e < 0 && is_req && for_us) begin
                        e = claim_entry();
                        if (e >= 0) begin
                            sh_ip[e] = r.sip; sh_held[e] = 1'b0;
                        end
                    end
                    if (e >= 0) begin
                        prior_pend = sh_status[e] == ENT_PENDING;
                        sh_mac[e] = r.smac; sh_status[e] = ENT_VALID; sh_tries[e] = '0;
                        sh_dl[e] = deadline_after(r.now, r_life);
                        if (prior_pend && sh_held[e]) begin
                            out.push_back(mk(KIND_RELEASE, STS_OK, r.smac, 0, e));
                            sh_held[e] = 1'b0;
                        end
                    end
                    if (is_req && for_us) out.push_back(mk(KIND_REPLY, STS_OK, r.smac, r.sip, 0));
                    out.push_back(mk(KIND_STATUS, STS_OK, 0, 0, 0));
                end
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r.now < sh_dl[i] || sh_status[i] == ENT_FREE) continue;
                    if (sh_status[i] == ENT_VALID) begin
                        sh_status[i] = ENT_FREE;
                    end else if (sh_tries[i] >= r_limit) begin
                        sh_status[i] = ENT_FREE;
                    end else begin
                        sh_tries[i] = sh_tries[i] + 4'd1;
                        sh_dl[i] = deadline_after(r.now, r_retry);
                        out.push_back(mk(KIND_REQUEST, STS_OK, MAC_BCAST, sh_ip[i], i));
                    end
                end
                out.push_back(mk(KIND_STATUS, STS_OK, 0, 0, 0));
            end
        endcase
        for (int i = 0; i < ENTRIES; i++) if (sh_status[i] == ENT_PENDING) pend++;
        foreach (out[k]) begin
            out[k].pend = 5'(pend);
            out[k].last = (k == out.size() - 1);
            expected_beats.push_back(out[k]);
        end
    endfunction

    function automatic int gap_len();
        int p;
        if (quiet) return 0;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_item(t_req r);
        int g;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= r.func;
        i_s_tdata  <= {6'b0, r.smac, r.sip, r.op, r.plen, r.hlen, r.ptype, r.htype,
                       r.long_ok, r.hold, r.addr, r.now};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_cache(r);
        g = gap_len();
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg idx, logic [47:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_OWN_IP:   r_own_ip  = val[31:0];
            CFG_OWN_MAC:  r_own_mac = val;
            CFG_RETRY:    r_retry   = val[31:0];
            CFG_LIFETIME: r_life    = val[31:0];
            default:      r_limit   = val[3:0];
        endcase
    endtask

    function automatic t_req base_item(t_func f, logic [31:0] addr);
        t_req r;
        r.func = f; r.now = now_t; r.addr = addr; r.hold = 1'b0; r.long_ok = 1'b1;
        r.htype = HW_ETHER; r.ptype = PROTO_IPV4; r.hlen = HW_ADDR_LEN;
        r.plen = PROTO_ADDR_LEN; r.op = 16'd2; r.sip = '0; r.smac = '0;
        return r;
    endfunction

    function automatic t_req frame_item(logic [31:0] target, logic [15:0] op,
                                        logic [31:0] sip, logic [47:0] smac);
        t_req r;
        r = base_item(FUNC_FRAME, target);
        r.op = op; r.sip = sip; r.smac = smac;
        return r;
    endfunction

    // well-formed traffic over a small address pool, with some noise
    function automatic t_req random_item(int max_step);
        t_req r;
        int   p;
        now_t = now_t + 48'($urandom_range(max_step));
        p = $urandom_range(99);
        r = base_item(FUNC_RESOLVE, ip_pool[$urandom_range(23)]);
        r.hold = 1'($urandom_range(1));
        r.sip = ip_pool[$urandom_range(23)];
        r.smac = 48'({$urandom, $urandom});
        r.op = $urandom_range(1) ? 16'd1 : 16'd2;
        if (p < 35) begin
            if ($urandom_range(19) == 0) r.addr = $urandom_range(1) ? 32'h0 : IP_BCAST;
            if ($urandom_range(19) == 0) r.addr = $urandom;
        end else if (p < 45) begin
            r.func = FUNC_LOOKUP;
        end else if (p < 80) begin
            r.func = FUNC_FRAME;
            r.addr = $urandom_range(1) ? r_own_ip : ($urandom_range(1) ? ip_pool[0] : $urandom);
            if ($urandom_range(9) == 0) r.op = 16'($urandom);
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(4))
                    0: r.long_ok = 1'b0;
                    1: r.htype = 16'($urandom);
                    2: r.ptype = 16'($urandom);
                    3: r.hlen = 8'($urandom);
                    default: r.plen = 8'($urandom);
                endcase
            end
        end else begin
            r.func = FUNC_TICK;
        end
        return r;
    endfunction

    task automatic test_directed();
        t_req r;
        write_reg(CFG_OWN_IP, 48'h0A00_0001);
        write_reg(CFG_OWN_MAC, 48'h0200_1122_3344);
        write_reg(CFG_RETRY, 48'd10);
        write_reg(CFG_LIFETIME, 48'd50);
        write_reg(CFG_LIMIT, 48'd2);
        send_item(base_item(FUNC_RESOLVE, IP_BCAST));
        send_item(base_item(FUNC_RESOLVE, 32'h0));
        r = base_item(FUNC_RESOLVE, 32'h0A00_0005); r.hold = 1'b1;
        send_item(r);
        send_item(base_item(FUNC_RESOLVE, 32'h0A00_0005));     // clears held mark
        send_item(base_item(FUNC_LOOKUP, 32'h0A00_0005));
        send_item(frame_item(32'h0A00_0001, 16'd2, 32'h0A00_0005, 48'hFFFF_FFFF_FFFF));
        r = base_item(FUNC_RESOLVE, 32'h0A00_0006); r.hold = 1'b1;
        send_item(r);
        send_item(frame_item(32'h0A00_0009, 16'd2, 32'h0A00_0006, 48'h0));   // release
        send_item(base_item(FUNC_LOOKUP, 32'h0A00_0006));
        send_item(base_item(FUNC_RESOLVE, 32'h0A00_0006));
        send_item(frame_item(32'h0A00_0001, 16'd1, 32'hFFFF_FFFE, 48'hA5A5_5A5A_0F0F));
        send_item(frame_item(32'h0A00_0002, 16'd1, 32'h0A00_0077, 48'h1));  // not learned
        r = frame_item(32'h0A00_0001, 16'd1, 32'h1, 48'h1); r.long_ok = 1'b0; send_item(r);
        r.long_ok = 1'b1; r.htype = 16'hFFFF; send_item(r);
        r.htype = HW_ETHER; r.ptype = 16'hFFFF; send_item(r);
        r.ptype = PROTO_IPV4; r.hlen = 8'hFF; send_item(r);
        r.hlen = HW_ADDR_LEN; r.plen = 8'hFF; send_item(r);
        r = base_item(FUNC_RESOLVE, 32'h0A00_0008); send_item(r);
        now_t = now_t + 48'd10; send_item(base_item(FUNC_TICK, 0));   // retry
        now_t = now_t + 48'd10; send_item(base_item(FUNC_TICK, 0));   // give up
        now_t = now_t + 48'd60;
        send_item(base_item(FUNC_LOOKUP, 32'h0A00_0006));             // expired lazily
        send_item(base_item(FUNC_TICK, 0));
        wait_drained();
    endtask

    task automatic test_full_cache();
        for (int i = 0; i < ENTRIES + 2; i++)
            send_item(base_item(FUNC_RESOLVE, 32'hC0A8_0100 + 32'(i)));
        send_item(base_item(FUNC_LOOKUP, 32'hC0A8_0100));
        now_t = now_t + 48'd1000;
        send_item(base_item(FUNC_TICK, 0));
        send_item(base_item(FUNC_TICK, 0));
        wait_drained();
    endtask

    task automatic test_random(int count, int max_step);
        for (int i = 0; i < count; i++) send_item(random_item(max_step));
        wait_drained();
    endtask

    initial begin
        foreach (ip_pool[i]) ip_pool[i] = 32'h0A00_0100 + 32'(i * 7 + 3);
        for (int i = 0; i < ENTRIES; i++) begin
            sh_status[i] = ENT_FREE; sh_ip[i] = '0; sh_mac[i] = '0;
            sh_dl[i] = '0; sh_tries[i] = '0; sh_held[i] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_random(40, 3000);
        test_directed();
        test_full_cache();
        write_reg(CFG_OWN_IP, {16'h0, ip_pool[0]});
        write_reg(CFG_LIMIT, 48'd15);
        write_reg(CFG_RETRY, 48'd1);
        write_reg(CFG_LIFETIME, 48'd40);
        quiet = 1;
        test_random(50, 6);
        quiet = 0;
        write_reg(CFG_LIMIT, 48'd1);
        write_reg(CFG_RETRY, 48'd20);
        write_reg(CFG_LIFETIME, 48'd1);
        test_random(60, 30);
        write_reg(CFG_LIMIT, 48'd4);
        write_reg(CFG_RETRY, 48'd15);
        write_reg(CFG_LIFETIME, 48'd200);
        write_reg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        test_random(110, 25);
        // deadlines near the top of the time range saturate, time stays monotonic
        write_reg(CFG_OWN_IP, 48'hFFFF_FFFF);
        write_reg(CFG_OWN_MAC, 48'h0);
        write_reg(CFG_RETRY, 48'hFFFF_FFFF);
        write_reg(CFG_LIFETIME, 48'hFFFF_FFFF);
        now_t = 48'hFFFF_FFF0_0000;
        test_random(40, 32'h4000);
        if (errors == 0) begin
            $display("tb_arp_neighbor_cache: clean");
        end else begin
            $display("tb_arp_neighbor_cache: errors");
        end
        $finish;
    end

    // result receiver with random back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(99) < 25) begin
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(2);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_beat x;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected beat kind=%0d tdata=%h", o_m_tuser, o_m_tdata);
                errors++;
            end else begin
                x = expected_beats.pop_front();
                if (o_m_tuser != x.kind) begin
                    $error("kind exp %0d got %0d", x.kind, o_m_tuser); errors++;
                end
                if (o_m_tdata[2:0] != x.sts) begin
                    $error("status exp %0d got %0d", x.sts, o_m_tdata[2:0]); errors++;
                end
                if (o_m_tdata[50:3] != x.mac) begin
                    $error("mac exp %h got %h", x.mac, o_m_tdata[50:3]); errors++;
                end
                if (o_m_tdata[82:51] != x.ip) begin
                    $error("ip exp %h got %h", x.ip, o_m_tdata[82:51]); errors++;
                end
                if (o_m_tdata[86:83] != x.slot) begin
                    $error("slot exp %0d got %0d", x.slot, o_m_tdata[86:83]); errors++;
                end
                if (o_m_tdata[91:87] != x.pend) begin
                    $error("pending_count exp %0d got %0d", x.pend, o_m_tdata[91:87]); errors++;
                end
                if (o_m_tlast != x.last) begin
                    $error("last exp %0d got %0d", x.last, o_m_tlast); errors++;
                end
            end
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb_arp_neighbor_cache: errors");
            $finish;
        end
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/anc_pkg.sv
rtl/anc_ram.sv
rtl/arp_neighbor_cache.sv
bench/tb_arp_neighbor_cache.sv
